// ===== rtl/imhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and constants for the indexed min-heap queue
// Defines the transaction structs, opcodes, status codes and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF    = 24;
    localparam int NODE_BITS       = 8;
    localparam int NODE_COUNT      = 256;
    localparam int IN_KEY_BITS     = KEY_BITS_DEF;
    localparam int COUNT_BITS      = $clog2(MAX_ENTRIES_DEF + 1);

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DECREASE = 2'd1;
    localparam logic [1:0] OP_POP      = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [NODE_BITS-1:0]   node_index;
        logic [IN_KEY_BITS-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [NODE_BITS-1:0]  popped_node;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out_item;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_LOAD     = 4'd1,  // capture input item
        DP_INS      = 4'd2,  // write key, append node, cur = count
        DP_DEC_RD   = 4'd3,  // write key, read slot_of_node
        DP_DEC_CHK  = 4'd4,  // read heap slot at candidate
        DP_DEC_GO   = 4'd5,  // validate candidate, set cur
        DP_UP_RD    = 4'd6,  // read cur and parent nodes
        DP_UP_KEY   = 4'd7,  // read their keys
        DP_UP_SWAP  = 4'd8,  // compare and swap up
        DP_POP_RD   = 4'd9,  // read root and last nodes
        DP_POP_MV   = 4'd10, // move last to root, read its key, cur = 1
        DP_DN_RD    = 4'd11, // read left and right nodes
        DP_DN_KEY   = 4'd12, // read the two child keys
        DP_DN_SWAP  = 4'd13, // compare and swap down
        DP_FIN      = 4'd14  // build result
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_decrease;
        logic is_pop;
        logic is_full;
        logic is_empty;
        logic up_done;   // sift-up cannot continue from cur
        logic dn_done;   // sift-down cannot continue from cur
        logic moved;     // last swap step moved the item
        logic dec_ok;    // decrease candidate is valid
    } t_dp_status;

endpackage

// ===== rtl/indexed_min_heap_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_unit: indexed binary min-heap priority queue
// Queues node numbers ordered by per-node unsigned keys; supports insert,
// decrease priority and pop minimum with a node-to-slot position map.
// ----------------------------------------------------------------------------
// Usage: drive a request transaction on i_in_valid / i_in_item; it is taken
// at a clock edge where i_in_valid is high and o_in_stall is low. Each
// request gives exactly one result transaction on o_out_valid / o_out_item,
// taken where o_out_valid is high and i_out_stall is low.
// Flow: a request is captured, then decoded; a full insert, an empty pop
// or opcode three goes straight to the result. A decrease first checks the
// node's slot. An insert or decrease sifts up and a pop sifts down; each
// compare step reads the slots, then their keys, then compares and swaps.
// A sift ends after a compare that does not swap, at the root or at a
// leaf, so a full heap needs at most eight steps. One request is in work
// at a time; the next is taken in the idle cycle after the previous result
// enters the output register.
// Reset clears the occupancy counter and the handshake state; the key,
// slot and position memories are not cleared. While the receiver stalls,
// the result register holds its value and the block finishes at most one
// more request, then waits.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_unit #(
    parameter int MAX_ENTRIES = imhq_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = imhq_pkg::KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  imhq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output imhq_pkg::t_out_item o_out_item
);
    imhq_pkg::t_dp_cmd    w_cmd;
    imhq_pkg::t_dp_status w_stat;
    imhq_pkg::t_out_item  w_res;
    logic                 w_full;

    imhq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_status_full(w_full)
    );

    imhq_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_result(w_res)
    );

    // The full flag is held by the controller; it overrides the status code.
    // Empty pop is flagged by the datapath from its captured state.
    logic r_full_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_q <= 1'b0;
        end else if (w_cmd.op == imhq_pkg::DP_FIN) begin
            r_full_q <= w_full;
        end
    end

    always_comb begin
        o_out_item = w_res;
        if (r_full_q) begin
            o_out_item.status = imhq_pkg::ST_FULL;
        end
    end

endmodule

// ===== rtl/imhq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_datapath: heap stores and compare/swap logic
// Holds key store, heap slots and position map as memories with registered
// reads, plus the occupancy counter and the sift cursor.
// ----------------------------------------------------------------------------
module imhq_datapath #(
    parameter int MAX_ENTRIES = imhq_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = imhq_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imhq_pkg::t_in_item   i_item,
    input  imhq_pkg::t_dp_cmd    i_cmd,
    output imhq_pkg::t_dp_status o_stat,
    output imhq_pkg::t_out_item  o_result
);
    localparam int SB = $clog2(MAX_ENTRIES + 1);  // slot / count width
    localparam int NB = imhq_pkg::NODE_BITS;
    localparam int CB = imhq_pkg::COUNT_BITS;

    logic [KEY_BITS-1:0] r_key_mem [imhq_pkg::NODE_COUNT];
    logic [NB-1:0]       r_heap_mem [MAX_ENTRIES + 1];
    logic [SB-1:0]       r_pos_mem [imhq_pkg::NODE_COUNT];

    imhq_pkg::t_in_item  r_item;
    logic [SB-1:0]       r_count;
    logic [SB-1:0]       r_cur;
    logic [SB-1:0]       r_cand;
    logic [NB-1:0]       r_n_cur, r_n_a, r_n_b;     // nodes: cur, parent/left, right
    logic [KEY_BITS-1:0] r_k_cur, r_k_a, r_k_b;
    logic                r_moved;
    logic [NB-1:0]       r_popped;
    logic                r_pop_ok;
    logic                r_dec_ok;
    imhq_pkg::t_out_item r_res;

    logic [KEY_BITS-1:0] w_key;
    logic [SB-1:0]       w_par, w_lc, w_rc, w_last;
    logic                w_has_r, w_pick_r;

    assign w_key  = KEY_BITS'(r_item.key_value);
    assign w_par  = r_cur >> 1;
    assign w_lc   = SB'(r_cur << 1);
    assign w_rc   = SB'((r_cur << 1) | SB'(1));
    assign w_last = r_count;  // on pop, r_count already holds occupancy-1
    assign w_has_r  = ({1'b0, w_rc} <= {1'b0, w_last});
    assign w_pick_r = w_has_r && (r_k_a > r_k_b);

    always_comb begin
        o_stat.is_insert   = (r_item.opcode == imhq_pkg::OP_INSERT);
        o_stat.is_decrease = (r_item.opcode == imhq_pkg::OP_DECREASE);
        o_stat.is_pop      = (r_item.opcode == imhq_pkg::OP_POP);
        o_stat.is_full     = ({1'b0, r_count} >= (SB+1)'(MAX_ENTRIES));
        o_stat.is_empty    = (r_count == '0);
        o_stat.up_done     = (r_cur <= SB'(1));
        o_stat.dn_done     = ({1'b0, r_cur, 1'b0} > {2'b0, w_last});
        o_stat.moved       = r_moved;
        o_stat.dec_ok      = r_dec_ok;
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.op)
                imhq_pkg::DP_INS:    r_count <= r_count + SB'(1);
                imhq_pkg::DP_POP_RD: r_count <= r_count - SB'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            imhq_pkg::DP_LOAD: begin
                r_item   <= i_item;
                r_popped <= '0;
                r_pop_ok <= 1'b0;
                r_dec_ok <= 1'b0;
                // The first sift step of a transaction is not stopped by the moved flag.
                r_moved  <= 1'b1;
            end
            imhq_pkg::DP_INS: begin
                r_key_mem[r_item.node_index] <= w_key;
                r_heap_mem[r_count + SB'(1)]  <= r_item.node_index;
                r_pos_mem[r_item.node_index] <= r_count + SB'(1);
                r_cur <= r_count + SB'(1);
            end
            imhq_pkg::DP_DEC_RD: begin
                r_key_mem[r_item.node_index] <= w_key;
                r_cand <= r_pos_mem[r_item.node_index];
            end
            imhq_pkg::DP_DEC_CHK: begin
                r_n_cur <= r_heap_mem[r_cand];
            end
            imhq_pkg::DP_DEC_GO: begin
                r_dec_ok <= (r_cand != '0) && (r_cand <= r_count)
                            && (r_n_cur == r_item.node_index);
                r_cur    <= r_cand;
            end
            imhq_pkg::DP_UP_RD: begin
                r_n_cur <= r_heap_mem[r_cur];
                r_n_a   <= r_heap_mem[w_par];
            end
            imhq_pkg::DP_UP_KEY: begin
                r_k_cur <= r_key_mem[r_n_cur];
                r_k_a   <= r_key_mem[r_n_a];
            end
            imhq_pkg::DP_UP_SWAP: begin
                r_moved <= (r_k_a > r_k_cur);
                if (r_k_a > r_k_cur) begin
                    r_heap_mem[w_par] <= r_n_cur;
                    r_heap_mem[r_cur] <= r_n_a;
                    r_pos_mem[r_n_cur] <= w_par;
                    r_pos_mem[r_n_a]   <= r_cur;
                    r_cur <= w_par;
                end
            end
            imhq_pkg::DP_POP_RD: begin
                r_n_a   <= r_heap_mem[SB'(1)];
                r_n_cur <= r_heap_mem[r_count];
                r_cand  <= r_count;
            end
            imhq_pkg::DP_POP_MV: begin
                // Swap root with last slot; old root leaves the heap. The
                // moved node and its key stay in r_n_cur / r_k_cur for the
                // whole sift-down.
                r_heap_mem[SB'(1)] <= r_n_cur;
                r_heap_mem[r_cand] <= r_n_a;
                r_pos_mem[r_n_cur] <= SB'(1);
                r_pos_mem[r_n_a]   <= r_cand;
                r_k_cur  <= r_key_mem[r_n_cur];
                r_popped <= r_n_a;
                r_pop_ok <= 1'b1;
                r_cur    <= SB'(1);
            end
            imhq_pkg::DP_DN_RD: begin
                r_n_a   <= r_heap_mem[w_lc];
                r_n_b   <= r_heap_mem[w_rc];
            end
            imhq_pkg::DP_DN_KEY: begin
                r_k_a   <= r_key_mem[r_n_a];
                r_k_b   <= r_key_mem[r_n_b];
            end
            imhq_pkg::DP_DN_SWAP: begin
                if (w_pick_r) begin
                    r_moved <= (r_k_cur > r_k_b);
                    if (r_k_cur > r_k_b) begin
                        r_heap_mem[w_rc]   <= r_n_cur;
                        r_heap_mem[r_cur]  <= r_n_b;
                        r_pos_mem[r_n_cur] <= w_rc;
                        r_pos_mem[r_n_b]   <= r_cur;
                        r_cur <= w_rc;
                    end
                end else begin
                    r_moved <= (r_k_cur > r_k_a);
                    if (r_k_cur > r_k_a) begin
                        r_heap_mem[w_lc]   <= r_n_cur;
                        r_heap_mem[r_cur]  <= r_n_a;
                        r_pos_mem[r_n_cur] <= w_lc;
                        r_pos_mem[r_n_a]   <= r_cur;
                        r_cur <= w_lc;
                    end
                end
            end
            imhq_pkg::DP_FIN: begin
                r_res.popped_node <= r_popped;
                r_res.entry_count <= CB'(r_count);
                if (o_stat.is_pop && !r_pop_ok) begin
                    r_res.status <= imhq_pkg::ST_EMPTY;
                end else begin
                    r_res.status <= imhq_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/imhq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_ctrl: sequencer for the indexed min-heap queue
// Steps the datapath through insert, decrease and pop, and runs the
// output handshake.
// ----------------------------------------------------------------------------
module imhq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  imhq_pkg::t_dp_status i_stat,
    output imhq_pkg::t_dp_cmd    o_cmd,
    output logic                 o_status_full
);
    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DECODE  = 12'b0000_0000_0010,
        S_DEC_CHK = 12'b0000_0000_0100,
        S_DEC_GO  = 12'b0000_0000_1000,
        S_UP_RD   = 12'b0000_0001_0000,
        S_UP_KEY  = 12'b0000_0010_0000,
        S_UP_SWAP = 12'b0000_0100_0000,
        S_POP_MV  = 12'b0000_1000_0000,
        S_DN_RD   = 12'b0001_0000_0000,
        S_DN_KEY  = 12'b0010_0000_0000,
        S_DN_SWAP = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   r_full, n_full;
    logic   w_take;

    // A new transaction is taken when idle; the finished result may still
    // be waiting in the output register meanwhile.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status_full = r_full;

    always_comb begin
        n_state = r_state;
        n_full  = r_full;
        o_cmd.op = imhq_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.op = imhq_pkg::DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_full = 1'b0;
                priority if (i_stat.is_insert) begin
                    if (i_stat.is_full) begin
                        n_full  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.op = imhq_pkg::DP_INS;
                        n_state  = S_UP_RD;
                    end
                end else if (i_stat.is_decrease) begin
                    o_cmd.op = imhq_pkg::DP_DEC_RD;
                    n_state  = S_DEC_CHK;
                end else if (i_stat.is_pop && !i_stat.is_empty) begin
                    o_cmd.op = imhq_pkg::DP_POP_RD;
                    n_state  = S_POP_MV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DEC_CHK: begin
                o_cmd.op = imhq_pkg::DP_DEC_CHK;
                n_state  = S_DEC_GO;
            end
            S_DEC_GO: begin
                o_cmd.op = imhq_pkg::DP_DEC_GO;
                n_state  = S_UP_RD;
            end
            S_UP_RD: begin
                // The moved flag reflects the previous compare step.
                if (i_stat.up_done || !i_stat.moved
                    || (i_stat.is_decrease && !i_stat.dec_ok)) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = imhq_pkg::DP_UP_RD;
                    n_state  = S_UP_KEY;
                end
            end
            S_UP_KEY: begin
                o_cmd.op = imhq_pkg::DP_UP_KEY;
                n_state  = S_UP_SWAP;
            end
            S_UP_SWAP: begin
                o_cmd.op = imhq_pkg::DP_UP_SWAP;
                n_state  = S_UP_RD;
            end
            S_POP_MV: begin
                o_cmd.op = imhq_pkg::DP_POP_MV;
                n_state  = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_stat.dn_done || !i_stat.moved) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = imhq_pkg::DP_DN_RD;
                    n_state  = S_DN_KEY;
                end
            end
            S_DN_KEY: begin
                o_cmd.op = imhq_pkg::DP_DN_KEY;
                n_state  = S_DN_SWAP;
            end
            S_DN_SWAP: begin
                o_cmd.op = imhq_pkg::DP_DN_SWAP;
                n_state  = S_DN_RD;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = imhq_pkg::DP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_full  <= n_full;
            r_state <= n_state;
            if (o_cmd.op == imhq_pkg::DP_FIN) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/imhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_checker: port-level checks for the heap queue
// Watches the handshakes and result codes seen at the top level's ports.
// ----------------------------------------------------------------------------
module imhq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input imhq_pkg::t_out_item o_out_item
);
    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed under stall");

    // After a request is taken, input stays stalled the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // A request that does not succeed reports node zero.
    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != imhq_pkg::ST_OK |->
        o_out_item.popped_node == '0)
        else $error("node reported on a failed request");

    // An empty pop leaves the queue empty.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == imhq_pkg::ST_EMPTY |->
        o_out_item.entry_count == '0)
        else $error("empty pop with entries");

endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
